// ===== sv/prq_pkg.sv =====
// shared types and codes of the priority ready queue
`default_nettype none
package prq_pkg;

   // operation codes of a request
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   // result status codes
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // fixed field widths
   localparam int ID_BITS       = 4;
   localparam int PRIO_PORT_BITS = 8;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic ins;
      logic rem;
   } prq_ctrl_type;

endpackage
`default_nettype wire

// ===== sv/priority_ready_queue.sv =====
// top level of the priority ready queue: row of slot cells and result register
`default_nettype none
// Stable sorted ready queue of process identifiers.
// A request (start high while busy is low) carries an operation, an
// identifier and a priority. Insert places the identifier after every
// queued entry of equal or higher priority; remove returns the head,
// the oldest entry of the highest priority.
// Slots form a row of cells, head in cell 0. Every cell compares its
// priority with the incoming one in parallel and loads from itself,
// its left neighbor, its right neighbor or the request, so a whole
// insert or remove completes in the cycle it is accepted.
// busy is always low: one request is taken every cycle.
// The result is registered and appears in the cycle after acceptance,
// marked by rsp_valid for exactly one cycle; the receiver cannot stall it.
// An insert into a full queue returns status full, a remove from an
// empty queue returns status empty; neither changes the queue.
// Synchronous reset empties the queue (the count goes to zero; slot
// contents are not cleared and are never read before being written).
module priority_ready_queue
   import prq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int PRIO_BITS   = 8,
   localparam int CNT_BITS   = $clog2(QUEUE_DEPTH + 1)
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic                      req_operation,
   input  wire logic [ID_BITS-1:0]        req_proc_id,
   input  wire logic [PRIO_PORT_BITS-1:0] req_prio,
   output logic                           rsp_valid,
   output logic [ID_BITS-1:0]             rsp_head_id,
   output logic [PRIO_PORT_BITS-1:0]      rsp_head_prio,
   output logic [1:0]                     rsp_status,
   output logic [CNT_BITS-1:0]            rsp_occupancy
);

   localparam int WIDE_BITS = 2 * PRIO_PORT_BITS;

   logic                      accept;
   logic                      full, empty;
   logic [PRIO_BITS-1:0]      new_prio;
   logic [WIDE_BITS-1:0]      req_prio_wide;
   logic [WIDE_BITS-1:0]      head_prio_wide;
   prq_ctrl_type              ctrl;

   logic [CNT_BITS-1:0]       count_ff, count_in;
   logic                      valid_ff;
   logic [ID_BITS-1:0]        head_id_ff, head_id_in;
   logic [PRIO_PORT_BITS-1:0] head_prio_ff, head_prio_in;
   logic [1:0]                status_ff, status_in;

   logic [QUEUE_DEPTH-1:0]    keep;
   logic [ID_BITS-1:0]        cell_id   [QUEUE_DEPTH];
   logic [PRIO_BITS-1:0]      cell_prio [QUEUE_DEPTH];

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign empty  = (count_ff == '0);

   // priority narrowed or widened to the stored width
   assign req_prio_wide  = {{PRIO_PORT_BITS{1'b0}}, req_prio};
   assign new_prio       = req_prio_wide[PRIO_BITS-1:0];
   assign head_prio_wide = WIDE_BITS'(cell_prio[0]);

   // command broadcast to the cells
   always_comb begin
      ctrl.ins = accept && (req_operation == OP_INSERT) && !full;
      ctrl.rem = accept && (req_operation == OP_REMOVE) && !empty;
   end

   // row of slot cells
   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      logic                 occ;
      logic                 lkeep;
      logic [ID_BITS-1:0]   lid, rid;
      logic [PRIO_BITS-1:0] lprio, rprio;

      assign occ = (CNT_BITS'(g) < count_ff);

      if (g == 0) begin : g_first
         assign lkeep = 1'b1;
         assign lid   = '0;
         assign lprio = '0;
      end else begin : g_mid
         assign lkeep = keep[g-1];
         assign lid   = cell_id[g-1];
         assign lprio = cell_prio[g-1];
      end

      if (g == QUEUE_DEPTH - 1) begin : g_last
         assign rid   = '0;
         assign rprio = '0;
      end else begin : g_inner
         assign rid   = cell_id[g+1];
         assign rprio = cell_prio[g+1];
      end

      prq_cell #(
         .PRIO_BITS(PRIO_BITS)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .occ       (occ),
         .left_keep (lkeep),
         .left_id   (lid),
         .left_prio (lprio),
         .right_id  (rid),
         .right_prio(rprio),
         .new_id    (req_proc_id),
         .new_prio  (new_prio),
         .keep      (keep[g]),
         .id        (cell_id[g]),
         .prio      (cell_prio[g])
      );
   end

   // count and result values
   always_comb begin
      count_in     = count_ff;
      head_id_in   = '0;
      head_prio_in = '0;
      status_in    = ST_DONE;
      if (ctrl.ins) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (ctrl.rem) begin
         count_in     = count_ff - CNT_BITS'(1);
         head_id_in   = cell_id[0];
         head_prio_in = head_prio_wide[PRIO_PORT_BITS-1:0];
      end else if (accept && (req_operation == OP_INSERT)) begin
         status_in = ST_FULL;
      end else if (accept) begin
         status_in = ST_EMPTY;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= accept;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      head_id_ff   <= head_id_in;
      head_prio_ff <= head_prio_in;
      status_ff    <= status_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_head_id   = head_id_ff;
   assign rsp_head_prio = head_prio_ff;
   assign rsp_status    = status_ff;
   assign rsp_occupancy = count_ff;

endmodule
`default_nettype wire

// ===== sv/prq_cell.sv =====
// one slot of the sorted queue: holds an entry, shifts with its neighbors
`default_nettype none
module prq_cell
   import prq_pkg::*;
#(
   parameter int PRIO_BITS = 8
) (
   input  wire logic                 clock,
   input  wire prq_ctrl_type         ctrl,
   input  wire logic                 occ,
   input  wire logic                 left_keep,
   input  wire logic [ID_BITS-1:0]   left_id,
   input  wire logic [PRIO_BITS-1:0] left_prio,
   input  wire logic [ID_BITS-1:0]   right_id,
   input  wire logic [PRIO_BITS-1:0] right_prio,
   input  wire logic [ID_BITS-1:0]   new_id,
   input  wire logic [PRIO_BITS-1:0] new_prio,
   output logic                      keep,
   output logic [ID_BITS-1:0]        id,
   output logic [PRIO_BITS-1:0]      prio
);

   logic [ID_BITS-1:0]   id_ff, id_in;
   logic [PRIO_BITS-1:0] prio_ff, prio_in;

   // entry stays put when it ranks equal or above the incoming one
   assign keep = occ && (prio_ff >= new_prio);

   // next slot contents
   always_comb begin
      id_in   = id_ff;
      prio_in = prio_ff;
      if (ctrl.rem) begin
         id_in   = right_id;
         prio_in = right_prio;
      end else if (ctrl.ins && !keep) begin
         if (left_keep) begin
            id_in   = new_id;
            prio_in = new_prio;
         end else begin
            id_in   = left_id;
            prio_in = left_prio;
         end
      end
   end

   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      prio_ff <= prio_in;
   end

   assign id   = id_ff;
   assign prio = prio_ff;

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// self-checking testbench of the priority ready queue: directed table, then random traffic
module tb_top;
   import prq_pkg::*;

   localparam int DEPTH      = 16;
   localparam int OCC_BITS   = $clog2(DEPTH + 1);
   localparam int RAND_REQS  = 625;
   localparam int CYCLE_CAP  = 60000;

   // one result record as the queue reports it
   typedef struct packed {
      logic [ID_BITS-1:0]        head_id;
      logic [PRIO_PORT_BITS-1:0] head_prio;
      logic [1:0]                status;
      logic [OCC_BITS-1:0]       occupancy;
   } queue_result_type;

   // one row of the directed table
   typedef struct {
      logic                      op;
      logic [ID_BITS-1:0]        id;
      logic [PRIO_PORT_BITS-1:0] prio;
      bit                        typed;
      queue_result_type          want;
   } probe_row_type;

   // traffic shapes of the random part
   typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic                      req_operation = OP_INSERT;
   logic [ID_BITS-1:0]        req_proc_id = '0;
   logic [PRIO_PORT_BITS-1:0] req_prio = '0;
   logic                      rsp_valid;
   logic [ID_BITS-1:0]        rsp_head_id;
   logic [PRIO_PORT_BITS-1:0] rsp_head_prio;
   logic [1:0]                rsp_status;
   logic [OCC_BITS-1:0]       rsp_occupancy;

   // shadow copy of the ready queue, head in entry 0
   logic [ID_BITS-1:0]        shadow_id [DEPTH];
   logic [PRIO_PORT_BITS-1:0] shadow_prio [DEPTH];
   int                        shadow_count = 0;

   queue_result_type awaited_results[$];
   probe_row_type    probe_rows[$];
   int               error_count = 0;
   int               cycle_count = 0;

   priority_ready_queue #(
      .QUEUE_DEPTH(DEPTH),
      .PRIO_BITS(8)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_operation(req_operation),
      .req_proc_id(req_proc_id),
      .req_prio(req_prio),
      .rsp_valid(rsp_valid),
      .rsp_head_id(rsp_head_id),
      .rsp_head_prio(rsp_head_prio),
      .rsp_status(rsp_status),
      .rsp_occupancy(rsp_occupancy)
   );

   always #10 clock = ~clock;

   // apply one request to the shadow queue and return the result it should give
   function automatic queue_result_type queue_apply(input logic op,
                                                    input logic [ID_BITS-1:0] id,
                                                    input logic [PRIO_PORT_BITS-1:0] prio);
      queue_result_type res;
      int pos;
      int i;
      res = '0;
      res.status = ST_DONE;
      if (op == OP_INSERT) begin
         if (shadow_count >= DEPTH) begin
            res.status = ST_FULL;
         end else begin
            // stable placement: behind every entry of equal or higher priority
            pos = 0;
            while (pos < shadow_count && shadow_prio[pos] >= prio) pos++;
            for (i = shadow_count; i > pos; i--) begin
               shadow_id[i]   = shadow_id[i-1];
               shadow_prio[i] = shadow_prio[i-1];
            end
            shadow_id[pos]   = id;
            shadow_prio[pos] = prio;
            shadow_count++;
         end
      end else begin
         if (shadow_count == 0) begin
            res.status = ST_EMPTY;
         end else begin
            res.head_id   = shadow_id[0];
            res.head_prio = shadow_prio[0];
            for (i = 1; i < shadow_count; i++) begin
               shadow_id[i-1]   = shadow_id[i];
               shadow_prio[i-1] = shadow_prio[i];
            end
            shadow_count--;
         end
      end
      res.occupancy = shadow_count[OCC_BITS-1:0];
      return res;
   endfunction

   function automatic probe_row_type make_row(input logic op, input logic [ID_BITS-1:0] id,
                                              input logic [PRIO_PORT_BITS-1:0] prio,
                                              input bit typed, input logic [ID_BITS-1:0] w_id,
                                              input logic [PRIO_PORT_BITS-1:0] w_prio,
                                              input logic [1:0] w_status,
                                              input logic [OCC_BITS-1:0] w_occ);
      probe_row_type row;
      row.op    = op;
      row.id    = id;
      row.prio  = prio;
      row.typed = typed;
      row.want  = {w_id, w_prio, w_status, w_occ};
      return row;
   endfunction

   // present one request and hold it until the queue takes it
   task automatic send_request(input logic op, input logic [ID_BITS-1:0] id,
                               input logic [PRIO_PORT_BITS-1:0] prio,
                               output queue_result_type res);
      req_operation <= op;
      req_proc_id   <= id;
      req_prio      <= prio;
      start         <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      res = queue_apply(op, id, prio);
   endtask

   // random idle gap between requests
   task automatic maybe_idle(input bit allowed);
      if (allowed && $urandom_range(0, 99) < 20) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // hold off until every outstanding result has come back
   task automatic drain_pause();
      start <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   // directed table: empty, extremes, head preemption, ties, full queue
   initial begin
      probe_rows.push_back(make_row(OP_REMOVE, 4'hF, 8'hFF, 1'b1, 4'h0, 8'h00, ST_EMPTY, 5'd0));
      probe_rows.push_back(make_row(OP_INSERT, 4'h5, 8'h00, 1'b1, 4'h0, 8'h00, ST_DONE, 5'd1));
      probe_rows.push_back(make_row(OP_INSERT, 4'hF, 8'hFF, 1'b1, 4'h0, 8'h00, ST_DONE, 5'd2));
      probe_rows.push_back(make_row(OP_REMOVE, 4'h0, 8'h00, 1'b1, 4'hF, 8'hFF, ST_DONE, 5'd1));
      probe_rows.push_back(make_row(OP_REMOVE, 4'hA, 8'h55, 1'b1, 4'h5, 8'h00, ST_DONE, 5'd0));
      probe_rows.push_back(make_row(OP_INSERT, 4'h0, 8'h40, 1'b0, '0, '0, '0, '0));
      probe_rows.push_back(make_row(OP_INSERT, 4'h1, 8'h40, 1'b0, '0, '0, '0, '0));
      probe_rows.push_back(make_row(OP_INSERT, 4'h2, 8'h01, 1'b0, '0, '0, '0, '0));
      probe_rows.push_back(make_row(OP_INSERT, 4'h3, 8'hFE, 1'b0, '0, '0, '0, '0));
      probe_rows.push_back(make_row(OP_INSERT, 4'h4, 8'h40, 1'b0, '0, '0, '0, '0));
      probe_rows.push_back(make_row(OP_INSERT, 4'h5, 8'h00, 1'b0, '0, '0, '0, '0));
      probe_rows.push_back(make_row(OP_INSERT, 4'h6, 8'hFF, 1'b0, '0, '0, '0, '0));
      probe_rows.push_back(make_row(OP_INSERT, 4'h7, 8'h80, 1'b0, '0, '0, '0, '0));
      probe_rows.push_back(make_row(OP_INSERT, 4'h8, 8'h7F, 1'b0, '0, '0, '0, '0));
      probe_rows.push_back(make_row(OP_INSERT, 4'h9, 8'h40, 1'b0, '0, '0, '0, '0));
      probe_rows.push_back(make_row(OP_INSERT, 4'hA, 8'hAA, 1'b0, '0, '0, '0, '0));
      probe_rows.push_back(make_row(OP_INSERT, 4'hB, 8'h55, 1'b0, '0, '0, '0, '0));
      probe_rows.push_back(make_row(OP_INSERT, 4'hC, 8'hFF, 1'b0, '0, '0, '0, '0));
      probe_rows.push_back(make_row(OP_INSERT, 4'hD, 8'h00, 1'b0, '0, '0, '0, '0));
      probe_rows.push_back(make_row(OP_INSERT, 4'hE, 8'h80, 1'b0, '0, '0, '0, '0));
      probe_rows.push_back(make_row(OP_INSERT, 4'hF, 8'h01, 1'b0, '0, '0, '0, '0));
      probe_rows.push_back(make_row(OP_INSERT, 4'h9, 8'hFF, 1'b1, 4'h0, 8'h00, ST_FULL, 5'd16));
      probe_rows.push_back(make_row(OP_REMOVE, 4'h3, 8'h10, 1'b0, '0, '0, '0, '0));
      probe_rows.push_back(make_row(OP_INSERT, 4'h3, 8'hFF, 1'b0, '0, '0, '0, '0));
      probe_rows.push_back(make_row(OP_REMOVE, 4'h0, 8'h00, 1'b0, '0, '0, '0, '0));
   end

   // stimulus
   initial begin
      queue_result_type res;
      traffic_mode_type mode;
      logic             op;
      logic [ID_BITS-1:0]        id;
      logic [PRIO_PORT_BITS-1:0] prio;
      int               ins_pct;
      mode = MODE_FILL;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // walk the directed table
      foreach (probe_rows[n]) begin
         send_request(probe_rows[n].op, probe_rows[n].id, probe_rows[n].prio, res);
         awaited_results.push_back(probe_rows[n].typed ? probe_rows[n].want : res);
         maybe_idle(1'b1);
      end
      drain_pause();

      // random part: randomly chosen fill, drain and mixed stretches
      for (int n = 0; n < RAND_REQS; n++) begin
         if (n % 32 == 0) mode = traffic_mode_type'($urandom_range(0, 2));
         case (mode)
            MODE_FILL:  ins_pct = 80;
            MODE_DRAIN: ins_pct = 20;
            default:    ins_pct = 50;
         endcase
         op = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_REMOVE;
         id = ID_BITS'($urandom_range(0, 15));
         // mix of full-range, tie-heavy and extreme priorities
         case ($urandom_range(0, 3))
            0, 1: prio = PRIO_PORT_BITS'($urandom_range(0, 255));
            2:    prio = PRIO_PORT_BITS'(8'h55 * $urandom_range(0, 3));
            default: prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         endcase
         send_request(op, id, prio, res);
         awaited_results.push_back(res);
         if (n == 400) drain_pause();
         else maybe_idle(n < 200 || n > 360);
      end

      // wind down and report
      start <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // field compare with report
   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   // result checker: each strobed result against the oldest expectation
   always @(posedge clock) begin
      queue_result_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (awaited_results.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result expected none actual %s %0d %0d %0d %0d",
                     $time, "id/prio/status/occ",
                     rsp_head_id, rsp_head_prio, rsp_status, rsp_occupancy);
         end else begin
            want = awaited_results.pop_front();
            check_field("head_id", 8'(want.head_id), 8'(rsp_head_id));
            check_field("head_prio", want.head_prio, rsp_head_prio);
            check_field("status", 8'(want.status), 8'(rsp_status));
            check_field("occupancy", 8'(want.occupancy), 8'(rsp_occupancy));
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_CAP) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

endmodule
